// File: hdl/sked_pkg.sv
// ============================================================================
// sked_pkg
// Types, constants and constant functions shared by the spherical kernel
// density evaluation pipeline.
// ============================================================================
`default_nettype none

package sked_pkg;

    typedef struct packed {
        logic signed [31:0] cos_dist;
        logic        [31:0] sigma;
    } sked_in_t;

    typedef struct packed {
        logic [47:0] density;
        logic        in_support;
    } sked_out_t;

    typedef struct packed {
        logic        live;
        logic [60:0] om;
        logic [31:0] sigma;
    } sked_ang_t;

    typedef struct packed {
        logic               live;
        logic        [60:0] om;
        logic        [63:0] xq;
        logic signed [63:0] g;
    } sked_nrm_t;

    localparam logic [63:0] PI_Q60       = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] HALF_PI_Q60  = 64'h1921_FB54_442D_1846;
    localparam logic [63:0] QUART_PI_Q60 = 64'h0C90_FDAA_2216_8C23;
    localparam logic [63:0] FOUR_PI_Q60  = 64'hC90F_DAA2_2168_C234;
    localparam logic [60:0] Q60_ONE      = 61'h1000_0000_0000_0000;
    localparam logic [47:0] DENS_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] SERIES_T0    = 64'h4000_0000_0000_0000 / 64'd24;

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;

    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 30;
    localparam int QUOT_BITS  = 48;

    // atan(2^-i) in Q60 from the odd power series, each term truncated
    function automatic logic [63:0] atan_q60(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned e;
        int unsigned k;
        acc = '0;
        if (i == 0)
        begin
            return QUART_PI_Q60;
        end
        for (k = 0; k < 31; k++)
        begin
            e = i * (2 * k + 1);
            if (e <= 60)
            begin
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                if (k % 2 == 1)
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sked_mul64.sv
// ============================================================================
// sked_mul64
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial
// products.
// ============================================================================
`default_nettype none

module sked_mul64 (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic      [127:0] p
);

    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            p01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            p10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg   <= {p11_reg, p00_reg} + {32'b0, p01_reg, 32'b0}
                       + {32'b0, p10_reg, 32'b0};
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: hdl/sked_angle.sv
// ============================================================================
// sked_angle
// Angle path: square root of 1-c^2, CORDIC arc tangent, division by sigma
// and 1 - rs^2, one step per pipeline stage.
// ============================================================================
`default_nettype none

module sked_angle
    import sked_pkg::*;
#(
    parameter int ITER = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire sked_in_t  in_data,
    output logic           out_valid,
    output sked_ang_t      out_data
);

    logic               v0_reg;
    logic signed [31:0] c0_reg;
    logic [31:0]        s0_reg;
    logic [31:0]        fac_a;
    logic [31:0]        fac_b;

    logic               sq_vld [0:ROOT_STEPS];
    logic [63:0]        sq_n   [0:ROOT_STEPS];
    logic [63:0]        sq_res [0:ROOT_STEPS];
    logic signed [31:0] sq_c   [0:ROOT_STEPS];
    logic [31:0]        sq_sig [0:ROOT_STEPS];
    logic               sq_hi  [0:ROOT_STEPS];
    logic               sq_lo  [0:ROOT_STEPS];

    logic               cd_vld [0:ITER];
    logic signed [63:0] cd_x   [0:ITER];
    logic signed [63:0] cd_y   [0:ITER];
    logic signed [63:0] cd_z   [0:ITER];
    logic [31:0]        cd_sig [0:ITER];
    logic               cd_hi  [0:ITER];
    logic               cd_lo  [0:ITER];

    logic               dv_vld  [0:DIV_STEPS];
    logic [29:0]        dv_lo   [0:DIV_STEPS];
    logic [31:0]        dv_rem  [0:DIV_STEPS];
    logic [29:0]        dv_q    [0:DIV_STEPS];
    logic [31:0]        dv_sig  [0:DIV_STEPS];
    logic               dv_live [0:DIV_STEPS];

    logic signed [63:0] x_init;
    logic signed [63:0] y_init;
    logic [63:0]        theta;
    logic [63:0]        sig_lim;
    logic [59:0]        rs_sq;

    logic               out_valid_reg;
    sked_ang_t          out_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= in_data.cos_dist;
            s0_reg <= in_data.sigma;
        end
    end

    // (1 - c)(1 + c)
    assign fac_a = 32'(ONE_Q30 - c0_reg);
    assign fac_b = 32'(ONE_Q30 + c0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n[0]   <= 64'(fac_a) * 64'(fac_b);
            sq_res[0] <= '0;
            sq_c[0]   <= c0_reg;
            sq_sig[0] <= s0_reg;
            sq_hi[0]  <= (c0_reg >= ONE_Q30);
            sq_lo[0]  <= (c0_reg <= NEG_ONE_Q30);
        end
    end

    // integer square root, one bit pair per stage
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;

        assign trial = sq_res[j] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld[j + 1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld[j + 1] <= sq_vld[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_n[j] >= trial)
                begin
                    sq_n[j + 1]   <= sq_n[j] - trial;
                    sq_res[j + 1] <= (sq_res[j] >> 1) + BIT;
                end
                else
                begin
                    sq_n[j + 1]   <= sq_n[j];
                    sq_res[j + 1] <= sq_res[j] >> 1;
                end
                sq_c[j + 1]   <= sq_c[j];
                sq_sig[j + 1] <= sq_sig[j];
                sq_hi[j + 1]  <= sq_hi[j];
                sq_lo[j + 1]  <= sq_lo[j];
            end
        end
    end

    // CORDIC start vector, rotated into the right half plane
    assign x_init = 64'(sq_c[ROOT_STEPS]) <<< 28;
    assign y_init = signed'({4'b0, sq_res[ROOT_STEPS][31:0], 28'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_vld[0] <= 1'b0;
        end
        else if (en)
        begin
            cd_vld[0] <= sq_vld[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_init < 0)
            begin
                cd_x[0] <= y_init;
                cd_y[0] <= -x_init;
                cd_z[0] <= signed'(HALF_PI_Q60);
            end
            else
            begin
                cd_x[0] <= x_init;
                cd_y[0] <= y_init;
                cd_z[0] <= '0;
            end
            cd_sig[0] <= sq_sig[ROOT_STEPS];
            cd_hi[0]  <= sq_hi[ROOT_STEPS];
            cd_lo[0]  <= sq_lo[ROOT_STEPS];
        end
    end

    for (genvar i = 0; i < ITER; i++)
    begin : g_cordic
        localparam logic signed [63:0] ATAN = signed'(atan_q60(i));
        logic signed [63:0] dx;
        logic signed [63:0] dy;

        assign dx = cd_y[i] >>> i;
        assign dy = cd_x[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_vld[i + 1] <= 1'b0;
            end
            else if (en)
            begin
                cd_vld[i + 1] <= cd_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cd_y[i] >= 0)
                begin
                    cd_x[i + 1] <= cd_x[i] + dx;
                    cd_y[i + 1] <= cd_y[i] - dy;
                    cd_z[i + 1] <= cd_z[i] + ATAN;
                end
                else
                begin
                    cd_x[i + 1] <= cd_x[i] - dx;
                    cd_y[i + 1] <= cd_y[i] + dy;
                    cd_z[i + 1] <= cd_z[i] - ATAN;
                end
                cd_sig[i + 1] <= cd_sig[i];
                cd_hi[i + 1]  <= cd_hi[i];
                cd_lo[i + 1]  <= cd_lo[i];
            end
        end
    end

    // pick the angle and check the support bound
    always_comb
    begin
        if (cd_hi[ITER])
        begin
            theta = '0;
        end
        else if (cd_lo[ITER])
        begin
            theta = PI_Q60;
        end
        else if (cd_z[ITER] < 0)
        begin
            theta = '0;
        end
        else
        begin
            theta = unsigned'(cd_z[ITER]);
        end
    end

    assign sig_lim = {2'b00, cd_sig[ITER], 30'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld[0] <= cd_vld[ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_lo[0]   <= theta[29:0];
            dv_rem[0]  <= theta[61:30];
            dv_q[0]    <= '0;
            dv_sig[0]  <= cd_sig[ITER];
            dv_live[0] <= (cd_sig[ITER] != '0) && (theta < sig_lim);
        end
    end

    // rs = theta / sigma, one quotient bit per stage
    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        localparam int POS = DIV_STEPS - 1 - s;
        logic [32:0] trial;

        assign trial = {dv_rem[s], dv_lo[s][POS]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld[s + 1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld[s + 1] <= dv_vld[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, dv_sig[s]})
                begin
                    dv_rem[s + 1]    <= 32'(trial - {1'b0, dv_sig[s]});
                    dv_q[s + 1]      <= dv_q[s] | (30'd1 << POS);
                end
                else
                begin
                    dv_rem[s + 1]    <= trial[31:0];
                    dv_q[s + 1]      <= dv_q[s];
                end
                dv_lo[s + 1]   <= dv_lo[s];
                dv_sig[s + 1]  <= dv_sig[s];
                dv_live[s + 1] <= dv_live[s];
            end
        end
    end

    assign rs_sq = 60'(dv_q[DIV_STEPS]) * 60'(dv_q[DIV_STEPS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.live  <= dv_live[DIV_STEPS];
            out_reg.om    <= Q60_ONE - {1'b0, rs_sq};
            out_reg.sigma <= dv_sig[DIV_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: hdl/sked_norm.sv
// ============================================================================
// sked_norm
// Kernel normalization series g(sigma^2), one series term per group of
// six pipeline stages.
// ============================================================================
`default_nettype none

module sked_norm
    import sked_pkg::*;
#(
    parameter int ITER = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire sked_ang_t  in_data,
    output logic            out_valid,
    output sked_nrm_t       out_data
);

    localparam int NT = ITER - 1;
    localparam logic signed [63:0] G0 = signed'(SERIES_T0 * 64'd3);

    logic        bnd_vld [0:NT];
    logic [63:0] bnd_t   [0:NT];
    sked_nrm_t   bnd_c   [0:NT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_vld[0] <= 1'b0;
        end
        else if (en)
        begin
            bnd_vld[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bnd_t[0]      <= SERIES_T0;
            bnd_c[0].live <= in_data.live;
            bnd_c[0].om   <= in_data.om;
            bnd_c[0].xq   <= 64'(in_data.sigma) * 64'(in_data.sigma);
            bnd_c[0].g    <= G0;
        end
    end

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam int          K    = j + 2;
        localparam logic [63:0] DIV  = 64'((2 * K + 1) * (2 * K + 2));
        localparam logic [63:0] COEF = 64'(2 * K + 1);
        localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / DIV;
        localparam bit          SUB  = (j % 2 == 0);

        logic        vd [1:5];
        sked_nrm_t   cd [1:5];
        logic [15:0] vl1_reg;
        logic [15:0] vl2_reg;
        logic [63:0] tc_reg;
        logic [127:0] pa;
        logic [127:0] pb;
        logic [63:0] q0;
        logic [31:0] qd;
        logic [15:0] rem;
        logic [63:0] t_next;
        logic [63:0] term;

        sked_mul64 u_mul_a (
            .clk (clk),
            .en  (en),
            .a   (bnd_t[j]),
            .b   (bnd_c[j].xq),
            .p   (pa)
        );

        sked_mul64 u_mul_b (
            .clk (clk),
            .en  (en),
            .a   (pa[123:60]),
            .b   (RECIP),
            .p   (pb)
        );

        // divide by the constant through its reciprocal, then fix up by one
        assign q0     = pb[127:64];
        assign qd     = 32'(q0[15:0]) * 32'(DIV[15:0]);
        assign rem    = vl2_reg - qd[15:0];
        assign t_next = q0 + 64'(rem >= DIV[15:0]);
        assign term   = COEF * tc_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd[1]          <= 1'b0;
                vd[2]          <= 1'b0;
                vd[3]          <= 1'b0;
                vd[4]          <= 1'b0;
                vd[5]          <= 1'b0;
                bnd_vld[j + 1] <= 1'b0;
            end
            else if (en)
            begin
                vd[1]          <= bnd_vld[j];
                vd[2]          <= vd[1];
                vd[3]          <= vd[2];
                vd[4]          <= vd[3];
                vd[5]          <= vd[4];
                bnd_vld[j + 1] <= vd[5];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd[1]        <= bnd_c[j];
                cd[2]        <= cd[1];
                cd[3]        <= cd[2];
                cd[4]        <= cd[3];
                cd[5]        <= cd[4];
                vl1_reg      <= pa[75:60];
                vl2_reg      <= vl1_reg;
                tc_reg       <= t_next;
                bnd_t[j + 1] <= tc_reg;
                bnd_c[j + 1].live <= cd[5].live;
                bnd_c[j + 1].om   <= cd[5].om;
                bnd_c[j + 1].xq   <= cd[5].xq;
                if (SUB)
                begin
                    bnd_c[j + 1].g <= cd[5].g - signed'(term);
                end
                else
                begin
                    bnd_c[j + 1].g <= cd[5].g + signed'(term);
                end
            end
        end
    end

    assign out_valid = bnd_vld[NT];
    assign out_data  = bnd_c[NT];

endmodule

`default_nettype wire

// File: hdl/sked_quot.sv
// ============================================================================
// sked_quot
// Norm scaling and the final restoring division (1 - rs^2) / norm with
// saturation, one quotient bit per stage.
// ============================================================================
`default_nettype none

module sked_quot
    import sked_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire sked_nrm_t  in_data,
    output logic            out_valid,
    output sked_out_t       out_data
);

    logic         vd [1:4];
    sked_nrm_t    cd [1:4];
    logic [127:0] ph;
    logic [127:0] pden;
    logic [127:0] num;
    logic         gneg;

    logic         qv    [0:QUOT_BITS];
    logic [127:0] qrem  [0:QUOT_BITS];
    logic [127:0] qden  [0:QUOT_BITS];
    logic [47:0]  qq    [0:QUOT_BITS];
    logic         qsat  [0:QUOT_BITS];
    logic         qlive [0:QUOT_BITS];

    logic         out_valid_reg;
    sked_out_t    out_reg;

    sked_mul64 u_mul_h (
        .clk (clk),
        .en  (en),
        .a   (FOUR_PI_Q60),
        .b   (unsigned'(in_data.g)),
        .p   (ph)
    );

    sked_mul64 u_mul_d (
        .clk (clk),
        .en  (en),
        .a   (cd[2].xq),
        .b   (ph[125:62]),
        .p   (pden)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd[1] <= 1'b0;
            vd[2] <= 1'b0;
            vd[3] <= 1'b0;
            vd[4] <= 1'b0;
            qv[0] <= 1'b0;
        end
        else if (en)
        begin
            vd[1] <= in_valid;
            vd[2] <= vd[1];
            vd[3] <= vd[2];
            vd[4] <= vd[3];
            qv[0] <= vd[4];
        end
    end

    assign num  = {31'b0, cd[4].om, 36'b0};
    assign gneg = cd[4].g[63] || (cd[4].g == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd[1]    <= in_data;
            cd[2]    <= cd[1];
            cd[3]    <= cd[2];
            cd[4]    <= cd[3];
            qrem[0]  <= num;
            qden[0]  <= pden;
            qq[0]    <= '0;
            qsat[0]  <= gneg || (num >= pden);
            qlive[0] <= cd[4].live;
        end
    end

    for (genvar s = 0; s < QUOT_BITS; s++)
    begin : g_step
        localparam int POS = QUOT_BITS - 1 - s;
        logic [128:0] trial;

        assign trial = {qrem[s], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qv[s + 1] <= 1'b0;
            end
            else if (en)
            begin
                qv[s + 1] <= qv[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, qden[s]})
                begin
                    qrem[s + 1] <= 128'(trial - {1'b0, qden[s]});
                    qq[s + 1]   <= qq[s] | (48'd1 << POS);
                end
                else
                begin
                    qrem[s + 1] <= trial[127:0];
                    qq[s + 1]   <= qq[s];
                end
                qden[s + 1]  <= qden[s];
                qsat[s + 1]  <= qsat[s];
                qlive[s + 1] <= qlive[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= qv[QUOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.in_support <= qlive[QUOT_BITS];
            if (!qlive[QUOT_BITS])
            begin
                out_reg.density <= '0;
            end
            else if (qsat[QUOT_BITS])
            begin
                out_reg.density <= DENS_MAX;
            end
            else
            begin
                out_reg.density <= qq[QUOT_BITS];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: hdl/spherical_kernel_density_eval_unit.sv
// ============================================================================
// spherical_kernel_density_eval_unit
// Epanechnikov kernel density on the sphere from the cosine of the angular
// distance and the smoothing length, fully pipelined.
// ============================================================================
// The unit takes one item per clock, except while the pipeline is held, and
// returns one result per item, in order. Every stage holds while the result
// register is full and stalled; the whole pipeline advances as one. The
// pipeline has 32 square root stages, TRIG_ITERATIONS CORDIC stages, 30
// stages for the scaled distance, six stages for each of the
// TRIG_ITERATIONS - 1 normalization series terms, and 48 stages for the
// final quotient, plus the register stages between them. Throughput is one
// transfer per cycle while the output is not stalled.
`default_nettype none

module spherical_kernel_density_eval_unit
    import sked_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire sked_in_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output sked_out_t      result
);

    logic      en;
    logic      ang_valid;
    sked_ang_t ang_data;
    logic      nrm_valid;
    sked_nrm_t nrm_data;

    // advance unless a finished result is held
    assign en         = !result_valid || !result_stall;
    assign item_stall = !en;

    sked_angle #(
        .ITER (TRIG_ITERATIONS)
    ) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .in_data   (item),
        .out_valid (ang_valid),
        .out_data  (ang_data)
    );

    sked_norm #(
        .ITER (TRIG_ITERATIONS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_valid),
        .in_data   (ang_data),
        .out_valid (nrm_valid),
        .out_data  (nrm_data)
    );

    sked_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nrm_valid),
        .in_data   (nrm_data),
        .out_valid (result_valid),
        .out_data  (result)
    );

    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.in_support |-> result.density == '0)
        else $error("nonzero density outside support");

    a_om_positive: assert property (@(posedge clk) disable iff (!rst_n)
        ang_valid && ang_data.live |-> ang_data.om != '0)
        else $error("in-support item with zero 1 - rs^2");

    a_xq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && nrm_data.live |-> nrm_data.xq != '0)
        else $error("in-support item with zero sigma squared");

endmodule

`default_nettype wire

// File: dv/sked_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// sked_checker
// Watches both channels of the spherical kernel density unit. It computes the
// expected density for every accepted input transfer and compares each
// output transfer, field by field, with the oldest expected result.
// ============================================================================
`default_nettype none

module sked_checker
    import sked_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire logic      item_stall,
    input  wire sked_in_t  item,
    input  wire logic      result_valid,
    input  wire logic      result_stall,
    input  wire sked_out_t result,
    output int             fail_count,
    output int             pending,
    output int             checked
);

    sked_out_t density_q[$];

    function automatic logic [63:0] arctan_pow2(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned k;
        sum = '0;
        if (i == 0)
        begin
            return 64'h0C90_FDAA_2216_8C23;
        end
        for (k = 0; i * (2 * k + 1) <= 60; k++)
        begin
            term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
            if (k % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] angle_of_cos(input longint c);
        logic [63:0] prod;
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint a;
        prod = (64'd1 << 30) - 64'(c);
        prod = prod * ((64'd1 << 30) + 64'(c));
        x = c * (longint'(1) << 28);
        y = longint'(int_sqrt(prod) << 28);
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = longint'(HALF_PI_Q60);
        end
        for (int i = 0; i < TRIG_ITERATIONS && i < 61; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            a = longint'(arctan_pow2(i));
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + a;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - a;
            end
        end
        return (z < 0) ? 64'd0 : 64'(z);
    endfunction

    function automatic longint norm_poly(input logic [63:0] x);
        logic [63:0] t;
        logic [127:0] p;
        longint g;
        logic neg;
        t = (64'd1 << 62) / 64'd24;
        g = 3 * longint'(t);
        neg = 1'b0;
        for (int unsigned k = 2; k < 2 + TRIG_ITERATIONS - 1; k++)
        begin
            p = 128'(t) * 128'(x);
            t = 64'(p >> 60) / 64'((2 * k + 1) * (2 * k + 2));
            neg = !neg;
            if (neg)
            begin
                g = g - longint'(64'(2 * k + 1) * t);
            end
            else
            begin
                g = g + longint'(64'(2 * k + 1) * t);
            end
        end
        return g;
    endfunction

    function automatic sked_out_t kernel_density(input sked_in_t it);
        sked_out_t r;
        longint c;
        logic [63:0] sig;
        logic [63:0] theta;
        logic [63:0] rs;
        logic [63:0] om;
        logic [63:0] xq;
        logic [63:0] h;
        logic [127:0] p;
        logic [191:0] quot;
        longint g;
        r = '0;
        c = longint'(it.cos_dist);
        sig = 64'(it.sigma);
        if (sig == 0)
        begin
            return r;
        end
        if (c >= (longint'(1) << 30))
        begin
            theta = 0;
        end
        else if (c <= -(longint'(1) << 30))
        begin
            theta = PI_Q60;
        end
        else
        begin
            theta = angle_of_cos(c);
        end
        rs = theta / sig;
        if (rs >= (64'd1 << 30))
        begin
            return r;
        end
        om = (64'd1 << 60) - rs * rs;
        xq = sig * sig;
        g = norm_poly(xq);
        r.in_support = 1'b1;
        if (g <= 0)
        begin
            r.density = DENS_MAX;
            return r;
        end
        p = 128'(FOUR_PI_Q60) * 128'(64'(g));
        h = 64'(p >> 62);
        p = 128'(xq) * 128'(h);
        if (p == 0)
        begin
            r.density = DENS_MAX;
            return r;
        end
        quot = (192'(om) << 84) / 192'(p);
        r.density = (quot >= (192'd1 << 48)) ? DENS_MAX : quot[47:0];
        return r;
    endfunction

    assign pending = density_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        sked_out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked <= 0;
            density_q.delete();
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                density_q.push_back(kernel_density(item));
            end
            if (result_valid && !result_stall)
            begin
                checked <= checked + 1;
                if (density_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                    begin
                        $display("unexpected transfer: density %h in_support %b",
                                 result.density, result.in_support);
                    end
                end
                else
                begin
                    want = density_q.pop_front();
                    if (want.density !== result.density
                        || want.in_support !== result.in_support)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                        begin
                            $display("mismatch: expected density %h in_support %b, got %h %b",
                                     want.density, want.in_support,
                                     result.density, result.in_support);
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/spherical_kernel_density_eval_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// spherical_kernel_density_eval_unit_tb
// Drives directed corner items and random items through the kernel density
// unit under several idle and stall patterns, including one long output
// hold-off that backs the pipeline up; a checker compares every result.
// ============================================================================
`default_nettype none

module spherical_kernel_density_eval_unit_tb;
    import sked_pkg::*;

    localparam int LATENCY = 7 * 32 + 116;
    localparam int LIMIT   = 400000;
    localparam int HOLD    = 1500;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    sked_in_t  item;
    logic      result_valid;
    logic      result_stall;
    sked_out_t result;
    int        fail_count;
    int        pending;
    int        checked;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_go;
    int        cycles;
    int        sent;

    spherical_kernel_density_eval_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    sked_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stall, plus one long hold-off on request
    initial
    begin
        int hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [31:0] c, input logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item.cos_dist <= c;
        item.sigma <= s;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        sent++;
    endtask

    function automatic logic [31:0] rand_cos();
        case ($urandom_range(3))
            0: return 32'h4000_0000 - $urandom_range(1 << 20);
            1: return 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
            2: return $urandom();
            default: return 32'hC000_0000 + $urandom_range(1 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_sigma();
        case ($urandom_range(4))
            0: return $urandom_range(1 << 28, 1);
            1: return $urandom_range(32'd3373259426);
            2: return $urandom();
            3: return $urandom_range(255);
            default: return $urandom_range(32'h4000_0000, 32'h0100_0000);
        endcase
    endfunction

    task automatic random_phase(input int n, input int sidle, input int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        repeat (n)
        begin
            send_item(rand_cos(), rand_sigma());
        end
    endtask

    initial
    begin
        cycles = 0;
        sent = 0;
        hold_go = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        item_valid = 1'b0;
        item = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(32'h4000_0000, 32'h0000_0001);
        send_item(32'h4000_0000, 32'h0000_0000);
        send_item(32'hC000_0000, 32'd3373259426);
        send_item(32'hC000_0000, 32'hFFFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h4000_0000);
        send_item(32'h8000_0000, 32'hC90F_DAA2);
        send_item(32'h0000_0000, 32'h4000_0000);
        send_item(32'h0000_0000, 32'd3373259426);
        send_item(32'h3FFF_FFFF, 32'h0000_0001);
        send_item(32'h3FFF_FFFF, 32'h0001_0000);
        send_item(32'hC000_0001, 32'hFFFF_FFFF);
        send_item(32'h2000_0000, 32'h4000_0000);
        send_item(32'hE000_0000, 32'h8000_0000);
        send_item(32'h3F00_0000, 32'h0800_0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h0000_0001, 32'h7FFF_FFFF);
        send_item(32'h4000_0000, 32'hFFFF_FFFF);
        send_item(32'h8000_0000, 32'h0000_0000);

        random_phase(120, 0, 0);
        random_phase(100, 84, 0);
        random_phase(100, 0, 84);
        random_phase(110, 17, 17);
        // hold the output long enough to back the pipeline up to the input
        hold_go = 1'b1;
        random_phase(120, 0, 0);

        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 20) @(posedge clk);

        $display("covered %0d input transfers, %0d results checked", sent, checked);
        $display("phases: directed corners, free flow, sender idle, receiver stall, both, hold-off");
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
